[design/led_status_blink_generator_top_defines.svh]
// Assertion macros for the status LED blink generator.
`ifndef LED_STATUS_BLINK_GENERATOR_TOP_DEFINES_SVH
`define LED_STATUS_BLINK_GENERATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LSBG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsbg assertion failed");
`define LSBG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsbg assertion failed");
`else
`define LSBG_ASSERT_IMP(label, ante, cons)
`define LSBG_ASSERT_NXT(label, ante, cons)
`endif

`endif

[design/lsbg_pkg.sv]
// Types and constants shared by the status LED blink generator.
package lsbg_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned TICK_W  = 10;
  localparam int unsigned TIMER_W = 17;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [DUTY_W-1:0]     duty_t;
  typedef logic [MS_W-1:0]       ms_t;
  typedef logic [TICK_W-1:0]     tick_t;
  typedef logic [TIMER_W-1:0]    timer_t;
  typedef logic [INDEX_W-1:0]    pidx_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF     = 3'd0,
    MODE_PULSE1  = 3'd1,
    MODE_PULSE2  = 3'd2,
    MODE_PULSE3  = 3'd3,
    MODE_FLASH_A = 3'd4,
    MODE_FLASH_B = 3'd5
  } mode_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLASH_ON    = 3'd0,
    CFG_FLASH_OFF   = 3'd1,
    CFG_PULSE_ON    = 3'd2,
    CFG_PULSE_OFF   = 3'd3,
    CFG_GROUP_PAUSE = 3'd4,
    CFG_TICK        = 3'd5,
    CFG_ON_DUTY     = 3'd6
  } cfg_reg_t;

  localparam ms_t   FLASH_ON_RST    = 16'd10;
  localparam ms_t   FLASH_OFF_RST   = 16'd90;
  localparam ms_t   PULSE_ON_RST    = 16'd200;
  localparam ms_t   PULSE_OFF_RST   = 16'd200;
  localparam ms_t   GROUP_PAUSE_RST = 16'd1000;
  localparam tick_t TICK_RST        = 10'd10;
  localparam duty_t ON_DUTY_RST     = 16'd100;

endpackage

[design/lsbg_in_if.sv]
// Input channel: one status-mode word per tick.
interface lsbg_in_if;
  import lsbg_pkg::*;

  logic  valid;
  logic  ready;
  mode_t status_mode;

  modport source (output valid, output status_mode, input ready);
  modport sink   (input valid, input status_mode, output ready);
endinterface

[design/lsbg_out_if.sv]
// Result channel: LED A and LED B duty word.
interface lsbg_out_if;
  import lsbg_pkg::*;

  logic  valid;
  logic  ready;
  duty_t led_a_duty;
  duty_t led_b_duty;

  modport source (output valid, output led_a_duty, output led_b_duty, input ready);
  modport sink   (input valid, input led_a_duty, input led_b_duty, output ready);
endinterface

[design/led_status_blink_generator_top.sv]
// Status LED blink generator: pulse-group and flash patterns to two PWM duty words.
// A result word is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one word per cycle while the skid register is empty; the timers update with a compare and add.
// A skid register keeps input ready while the output is stalled, until it holds a word.
// Reset (rst_n, synchronous): timers, pulse state and flags cleared,
// configuration registers return to their default values.
`include "led_status_blink_generator_top_defines.svh"

module led_status_blink_generator_top (
  input  logic                 clk,
  input  logic                 rst_n,
  lsbg_in_if.sink              in_chan,
  lsbg_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  lsbg_pkg::cfg_idx_t   cfg_idx,
  input  lsbg_pkg::cfg_data_t  cfg_wdata
);
  import lsbg_pkg::*;

  // configuration
  ms_t   flash_on_r, flash_off_r, pulse_on_r, pulse_off_r, group_pause_r;
  tick_t tick_r;
  duty_t on_duty_r;

  // pattern state
  logic   flash_lit_r, pulse_lit_r;
  timer_t flash_el_r, pulse_el_r;
  pidx_t  pulse_idx_r;

  // output and skid stages
  logic  out_v_r, skid_v_r;
  duty_t out_a_r, out_b_r, skid_a_r, skid_b_r;

  logic   accept;
  logic   is_pulse, is_flash_a, is_flash_b;
  logic   f_end, f_lit_nxt;
  timer_t f_el_nxt;
  logic   in_grp, p_end, p_lit_nxt;
  pidx_t  p_idx_nxt;
  timer_t p_el_nxt;
  duty_t  res_a, res_b;

  assign in_chan.ready = !skid_v_r;
  assign accept = in_chan.valid && !skid_v_r;

  always_comb begin
    is_pulse   = 1'b0;
    is_flash_a = 1'b0;
    is_flash_b = 1'b0;
    unique case (in_chan.status_mode)
      MODE_PULSE1, MODE_PULSE2, MODE_PULSE3: is_pulse = 1'b1;
      MODE_FLASH_A: is_flash_a = 1'b1;
      MODE_FLASH_B: is_flash_b = 1'b1;
      default: ;
    endcase
  end

  // flash timer step
  assign f_end     = flash_lit_r ? (flash_el_r >= {1'b0, flash_on_r})
                                 : (flash_el_r >= {1'b0, flash_off_r});
  assign f_lit_nxt = flash_lit_r ^ f_end;
  assign f_el_nxt  = (f_end ? '0 : flash_el_r) + {7'd0, tick_r};

  // pulse group step; group size is the low two mode bits
  assign in_grp = {1'b0, in_chan.status_mode[1:0]} >= pulse_idx_r;

  always_comb begin
    p_lit_nxt = pulse_lit_r;
    p_idx_nxt = pulse_idx_r;
    if (in_grp) begin
      if (pulse_lit_r) begin
        p_end = pulse_el_r >= {1'b0, pulse_on_r};
        if (p_end) begin
          p_lit_nxt = 1'b0;
          p_idx_nxt = pulse_idx_r + 3'd1;
        end
      end else begin
        p_end = pulse_el_r >= {1'b0, pulse_off_r};
        if (p_end) begin
          p_lit_nxt = 1'b1;
        end
      end
    end else begin
      p_end = pulse_el_r >= {1'b0, group_pause_r};
      if (p_end) begin
        p_lit_nxt = 1'b1;
        p_idx_nxt = 3'd1;
      end
    end
  end

  assign p_el_nxt = (p_end ? '0 : pulse_el_r) + {7'd0, tick_r};

  assign res_a = ((is_pulse && p_lit_nxt) || (is_flash_a && f_lit_nxt)) ? on_duty_r : '0;
  assign res_b = (is_flash_b && f_lit_nxt) ? on_duty_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_on_r    <= FLASH_ON_RST;
      flash_off_r   <= FLASH_OFF_RST;
      pulse_on_r    <= PULSE_ON_RST;
      pulse_off_r   <= PULSE_OFF_RST;
      group_pause_r <= GROUP_PAUSE_RST;
      tick_r        <= TICK_RST;
      on_duty_r     <= ON_DUTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FLASH_ON:    flash_on_r    <= cfg_wdata;
        CFG_FLASH_OFF:   flash_off_r   <= cfg_wdata;
        CFG_PULSE_ON:    pulse_on_r    <= cfg_wdata;
        CFG_PULSE_OFF:   pulse_off_r   <= cfg_wdata;
        CFG_GROUP_PAUSE: group_pause_r <= cfg_wdata;
        CFG_TICK:        tick_r        <= cfg_wdata[TICK_W-1:0];
        CFG_ON_DUTY:     on_duty_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_lit_r <= 1'b0;
      flash_el_r  <= '0;
      pulse_lit_r <= 1'b0;
      pulse_el_r  <= '0;
      pulse_idx_r <= '0;
    end else if (accept) begin
      if (is_flash_a || is_flash_b) begin
        flash_lit_r <= f_lit_nxt;
        flash_el_r  <= f_el_nxt;
      end
      if (is_pulse) begin
        pulse_lit_r <= p_lit_nxt;
        pulse_el_r  <= p_el_nxt;
        pulse_idx_r <= p_idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || out_chan.ready) begin
        out_v_r  <= skid_v_r || accept;
        skid_v_r <= 1'b0;
      end else if (accept) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_chan.ready) begin
      if (skid_v_r) begin
        out_a_r <= skid_a_r;
        out_b_r <= skid_b_r;
      end else if (accept) begin
        out_a_r <= res_a;
        out_b_r <= res_b;
      end
    end else if (accept) begin
      skid_a_r <= res_a;
      skid_b_r <= res_b;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.led_a_duty = out_a_r;
  assign out_chan.led_b_duty = out_b_r;

  `LSBG_ASSERT_IMP(a_skid_needs_out, skid_v_r, out_v_r)
  `LSBG_ASSERT_IMP(a_one_led_lit, out_v_r, (out_a_r == '0) || (out_b_r == '0))
  `LSBG_ASSERT_IMP(a_pulse_idx_range, 1'b1, pulse_idx_r <= 3'd4)
  `LSBG_ASSERT_NXT(a_off_holds_state, accept && !is_pulse && !is_flash_a && !is_flash_b,
                   $stable(pulse_el_r) && $stable(flash_el_r) && $stable(pulse_idx_r))
  `LSBG_ASSERT_NXT(a_skid_drains, skid_v_r && out_chan.ready, !skid_v_r)

endmodule
